FILE: rtl/core/cks_pkg.sv
// ----------------------------------------------------------------------------
// cks_pkg - codepoint to keystroke sequencer definitions
// Word types, sequencer states, key codes and the printable ASCII key table.
// ----------------------------------------------------------------------------
package cks_pkg;

  localparam int unsigned CpW    = 21;
  localparam int unsigned KeyW   = 8;
  localparam int unsigned NibW   = 4;
  localparam int unsigned MaxDig = 6;
  localparam int unsigned ValW   = NibW * MaxDig;
  localparam int unsigned CntW   = 3;

  localparam logic [KeyW-1:0] VkLShift = 8'hA0;
  localparam logic [KeyW-1:0] VkLCtrl  = 8'hA2;
  localparam logic [KeyW-1:0] VkU      = 8'h55;
  localparam logic [KeyW-1:0] VkDigit0 = 8'h30;
  localparam logic [KeyW-1:0] VkLetter = 8'h41;

  localparam logic [CpW-1:0] PrintLo = 21'h20;
  localparam logic [CpW-1:0] PrintHi = 21'h7E;

  // Input, output and configuration words
  typedef struct packed {
    logic [CpW-1:0] codepoint;
  } cp_word_t;

  typedef struct packed {
    logic [KeyW-1:0] key_code;
    logic            is_release;
    logic            last_of_run;
  } key_word_t;

  typedef struct packed {
    logic keyboard_attached;
  } cfg_word_t;

  // Sequencer to digit unit
  typedef struct packed {
    logic           load;
    logic           step;
    logic [CpW-1:0] value;
  } digit_ctl_t;

  // Digit unit to sequencer
  typedef struct packed {
    logic            rdy;   // leading zeros skipped, nibble is valid
    logic            last;  // current nibble is the final digit
    logic [NibW-1:0] nibble;
  } digit_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_SHIFT_DN,
    ST_A_KEY_DN,
    ST_A_KEY_UP,
    ST_A_SHIFT_UP,
    ST_H_CTRL_DN,
    ST_H_SHIFT_DN,
    ST_H_U_DN,
    ST_H_U_UP,
    ST_H_DIG_DN,
    ST_H_DIG_UP,
    ST_H_SHIFT_UP,
    ST_H_CTRL_UP
  } seq_state_e;

  // Bit 8 = Shift needed, low byte = key code; entries for 0x20..0x7E
  localparam int unsigned AsciiN = 95;
  localparam logic [8:0] AsciiKeys [AsciiN] = '{
    9'h020, 9'h131, 9'h1DE, 9'h133, 9'h134, 9'h135, 9'h137, 9'h0DE,
    9'h139, 9'h130, 9'h138, 9'h1BB, 9'h0BC, 9'h0BD, 9'h0BE, 9'h0BF,
    9'h030, 9'h031, 9'h032, 9'h033, 9'h034, 9'h035, 9'h036, 9'h037,
    9'h038, 9'h039, 9'h1BA, 9'h0BA, 9'h1BC, 9'h0BB, 9'h1BE, 9'h1BF,
    9'h132, 9'h141, 9'h142, 9'h143, 9'h144, 9'h145, 9'h146, 9'h147,
    9'h148, 9'h149, 9'h14A, 9'h14B, 9'h14C, 9'h14D, 9'h14E, 9'h14F,
    9'h150, 9'h151, 9'h152, 9'h153, 9'h154, 9'h155, 9'h156, 9'h157,
    9'h158, 9'h159, 9'h15A, 9'h0DB, 9'h0DC, 9'h0DD, 9'h136, 9'h1BD,
    9'h0C0, 9'h041, 9'h042, 9'h043, 9'h044, 9'h045, 9'h046, 9'h047,
    9'h048, 9'h049, 9'h04A, 9'h04B, 9'h04C, 9'h04D, 9'h04E, 9'h04F,
    9'h050, 9'h051, 9'h052, 9'h053, 9'h054, 9'h055, 9'h056, 9'h057,
    9'h058, 9'h059, 9'h05A, 9'h1DB, 9'h1DC, 9'h1DD, 9'h1C0
  };

  function automatic logic is_printable(input logic [CpW-1:0] cp);
    return (cp >= PrintLo) && (cp <= PrintHi);
  endfunction

  function automatic logic [8:0] ascii_key(input logic [CpW-1:0] cp);
    logic [6:0] idx;
    idx = 7'(cp - PrintLo);
    if (idx < 7'(AsciiN)) begin
      return AsciiKeys[idx];
    end
    return 9'h000;
  endfunction

  function automatic logic [KeyW-1:0] hex_key(input logic [NibW-1:0] d);
    if (d < 4'd10) begin
      return VkDigit0 + KeyW'(d);
    end
    return VkLetter + KeyW'(d - 4'd10);
  endfunction

endpackage

FILE: rtl/core/cks_word_if.sv
// ----------------------------------------------------------------------------
// cks_word_if - valid/ready channel
// Carries one word of type T per handshake.
// ----------------------------------------------------------------------------
interface cks_word_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/cks_digit_unit.sv
// ----------------------------------------------------------------------------
// cks_digit_unit - hex digit shifter
// Holds the codepoint as six nibbles, skips leading zeros one nibble a cycle
// and steps to the next digit on request.
// ----------------------------------------------------------------------------
module cks_digit_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cks_pkg::digit_ctl_t ctl_i,
  output cks_pkg::digit_sts_t sts_o
);

  logic [cks_pkg::ValW-1:0] val_q, val_d;
  logic [cks_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                     normed_q, normed_d;
  logic [cks_pkg::NibW-1:0] top_nib;
  logic                     single;

  assign top_nib = val_q[cks_pkg::ValW-1 -: cks_pkg::NibW];
  assign single  = (cnt_q == cks_pkg::CntW'(1));

  assign sts_o.rdy    = normed_q || (top_nib != '0) || single;
  assign sts_o.last   = single;
  assign sts_o.nibble = top_nib;

  always_comb begin
    val_d    = val_q;
    cnt_d    = cnt_q;
    normed_d = normed_q;
    if (ctl_i.load) begin
      val_d    = cks_pkg::ValW'(ctl_i.value);
      cnt_d    = cks_pkg::CntW'(cks_pkg::MaxDig);
      normed_d = 1'b0;
    end else if (ctl_i.step && !single) begin
      val_d = val_q << cks_pkg::NibW;
      cnt_d = cnt_q - cks_pkg::CntW'(1);
    end else if (!normed_q) begin
      if ((top_nib == '0) && !single) begin
        // leading zero: drop it
        val_d = val_q << cks_pkg::NibW;
        cnt_d = cnt_q - cks_pkg::CntW'(1);
      end else begin
        normed_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= cks_pkg::CntW'(1);
      normed_q <= 1'b1;
    end else begin
      cnt_q    <= cnt_d;
      normed_q <= normed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

FILE: rtl/core/cks_event_seq.sv
// ----------------------------------------------------------------------------
// cks_event_seq - key event sequencer
// Walks one codepoint through its press/release run and holds the event
// word in an output register.
// ----------------------------------------------------------------------------
module cks_event_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                kbd_i,
  cks_word_if.sink            in_i,
  cks_word_if.source          out_o,
  output cks_pkg::digit_ctl_t dctl_o,
  input  cks_pkg::digit_sts_t dsts_i
);

  cks_pkg::seq_state_e         state_q, state_d;
  logic [cks_pkg::KeyW-1:0]    key_q, key_d;
  logic                        shift_q, shift_d;
  logic                        ov_q, ov_d;
  cks_pkg::key_word_t          ev_q, ev_d;
  logic                        ld;
  logic                        emit;
  cks_pkg::key_word_t          ev_new;
  logic [8:0]                  entry;

  assign ld    = !ov_q || out_o.ready;
  assign entry = cks_pkg::ascii_key(in_i.data.codepoint);

  assign out_o.valid = ov_q;
  assign out_o.data  = ev_q;

  always_comb begin
    state_d       = state_q;
    key_d         = key_q;
    shift_d       = shift_q;
    in_i.ready    = 1'b0;
    emit          = 1'b0;
    ev_new        = '0;
    dctl_o.load   = 1'b0;
    dctl_o.step   = 1'b0;
    dctl_o.value  = in_i.data.codepoint;

    case (state_q)
      cks_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid && kbd_i) begin
          if (cks_pkg::is_printable(in_i.data.codepoint)) begin
            key_d   = entry[7:0];
            shift_d = entry[8];
            state_d = entry[8] ? cks_pkg::ST_A_SHIFT_DN : cks_pkg::ST_A_KEY_DN;
          end else begin
            dctl_o.load = 1'b1;
            state_d     = cks_pkg::ST_H_CTRL_DN;
          end
        end
      end
      cks_pkg::ST_A_SHIFT_DN: begin
        emit            = ld;
        ev_new.key_code = cks_pkg::VkLShift;
        if (ld) state_d = cks_pkg::ST_A_KEY_DN;
      end
      cks_pkg::ST_A_KEY_DN: begin
        emit            = ld;
        ev_new.key_code = key_q;
        if (ld) state_d = cks_pkg::ST_A_KEY_UP;
      end
      cks_pkg::ST_A_KEY_UP: begin
        emit               = ld;
        ev_new.key_code    = key_q;
        ev_new.is_release  = 1'b1;
        ev_new.last_of_run = !shift_q;
        if (ld) state_d = shift_q ? cks_pkg::ST_A_SHIFT_UP : cks_pkg::ST_IDLE;
      end
      cks_pkg::ST_A_SHIFT_UP: begin
        emit               = ld;
        ev_new.key_code    = cks_pkg::VkLShift;
        ev_new.is_release  = 1'b1;
        ev_new.last_of_run = 1'b1;
        if (ld) state_d = cks_pkg::ST_IDLE;
      end
      cks_pkg::ST_H_CTRL_DN: begin
        emit            = ld;
        ev_new.key_code = cks_pkg::VkLCtrl;
        if (ld) state_d = cks_pkg::ST_H_SHIFT_DN;
      end
      cks_pkg::ST_H_SHIFT_DN: begin
        emit            = ld;
        ev_new.key_code = cks_pkg::VkLShift;
        if (ld) state_d = cks_pkg::ST_H_U_DN;
      end
      cks_pkg::ST_H_U_DN: begin
        emit            = ld;
        ev_new.key_code = cks_pkg::VkU;
        if (ld) state_d = cks_pkg::ST_H_U_UP;
      end
      cks_pkg::ST_H_U_UP: begin
        emit              = ld;
        ev_new.key_code   = cks_pkg::VkU;
        ev_new.is_release = 1'b1;
        if (ld) state_d = cks_pkg::ST_H_DIG_DN;
      end
      cks_pkg::ST_H_DIG_DN: begin
        // wait here until the leading zeros are gone
        emit            = ld && dsts_i.rdy;
        ev_new.key_code = cks_pkg::hex_key(dsts_i.nibble);
        if (ld && dsts_i.rdy) state_d = cks_pkg::ST_H_DIG_UP;
      end
      cks_pkg::ST_H_DIG_UP: begin
        emit              = ld;
        ev_new.key_code   = cks_pkg::hex_key(dsts_i.nibble);
        ev_new.is_release = 1'b1;
        if (ld) begin
          dctl_o.step = 1'b1;
          state_d     = dsts_i.last ? cks_pkg::ST_H_SHIFT_UP : cks_pkg::ST_H_DIG_DN;
        end
      end
      cks_pkg::ST_H_SHIFT_UP: begin
        emit              = ld;
        ev_new.key_code   = cks_pkg::VkLShift;
        ev_new.is_release = 1'b1;
        if (ld) state_d = cks_pkg::ST_H_CTRL_UP;
      end
      cks_pkg::ST_H_CTRL_UP: begin
        emit               = ld;
        ev_new.key_code    = cks_pkg::VkLCtrl;
        ev_new.is_release  = 1'b1;
        ev_new.last_of_run = 1'b1;
        if (ld) state_d = cks_pkg::ST_IDLE;
      end
      default: begin
        state_d = cks_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    ev_d = ev_q;
    if (emit) begin
      ov_d = 1'b1;
      ev_d = ev_new;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cks_pkg::ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    shift_q <= shift_d;
    ev_q    <= ev_d;
  end

endmodule

FILE: rtl/core/codepoint_to_keystroke_sequencer_core.sv
// Codepoint to keystroke sequencer. Each accepted codepoint word becomes a
// run of key press/release words, one per cycle while the sink keeps ready
// high and the digit shifter has a digit ready; the final word of a run
// carries last_of_run. Printable ASCII (0x20..0x7E) gives 2 events, or 4
// with left Shift wrapped round; anything else is typed as the hex-entry
// chord Ctrl+Shift+U, digits, and releases, 6 + 2*digits events (8 to 18).
// The sequencer emits one event a cycle while the sink keeps ready high, and
// the digit shifter drops one leading zero nibble a cycle while the prefix
// keys go out. The input is not ready while a run is in progress. With
// keyboard_attached low a codepoint is taken and dropped. keyboard_attached
// resets to 1 and is written through cfg_i, which is always ready.
// ----------------------------------------------------------------------------
// codepoint_to_keystroke_sequencer_core - top level
// Configuration register, event sequencer and hex digit shifter.
// ----------------------------------------------------------------------------
module codepoint_to_keystroke_sequencer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  cks_word_if.sink   cfg_i,
  cks_word_if.sink   in_i,
  cks_word_if.source out_o
);

  // keyboard_attached register; the user must write it only while idle, the block does not enforce this
  logic kbd_q, kbd_d;

  // control and status between sequencer and digit shifter
  cks_pkg::digit_ctl_t dctl;
  cks_pkg::digit_sts_t dsts;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    kbd_d = kbd_q;
    if (cfg_i.valid) begin
      kbd_d = cfg_i.data.keyboard_attached;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kbd_q <= 1'b1;
    end else begin
      kbd_q <= kbd_d;
    end
  end

  // sequencer: owns the codepoint and key event handshakes and the output register
  cks_event_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .kbd_i  (kbd_q),
    .in_i   (in_i),
    .out_o  (out_o),
    .dctl_o (dctl),
    .dsts_i (dsts)
  );

  // nibble shifter: zero skipping and digit stepping
  cks_digit_unit u_digit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dctl),
    .sts_o  (dsts)
  );

endmodule

FILE: verif/keystroke_run_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keystroke_run_checker - key event predictor and comparator
// Watches the configuration, codepoint and key event channels, works out the
// key event run due for each accepted codepoint and compares every key event
// word with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module keystroke_run_checker import cks_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  cfg_word_t   cfg_data_i,
  input  logic        cp_valid_i,
  input  logic        cp_ready_i,
  input  cp_word_t    cp_data_i,
  input  logic        key_valid_i,
  input  logic        key_ready_i,
  input  key_word_t   key_data_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned outstanding_o
);

  localparam int unsigned MaxReported = 10;

  localparam logic [7:0] KeyLShift  = 8'hA0;
  localparam logic [7:0] KeyLCtrl   = 8'hA2;
  localparam logic [7:0] KeyU       = 8'h55;
  localparam logic [7:0] KeyDigit0  = 8'h30;
  localparam logic [7:0] KeyLetterA = 8'h41;
  localparam logic       Press      = 1'b0;
  localparam logic       Release    = 1'b1;

  // US layout, 0x20..0x7E; bit 8 set where Shift is held
  localparam logic [8:0] UsKeymap [95] = '{
    9'h020, 9'h131, 9'h1DE, 9'h133, 9'h134, 9'h135, 9'h137, 9'h0DE,
    9'h139, 9'h130, 9'h138, 9'h1BB, 9'h0BC, 9'h0BD, 9'h0BE, 9'h0BF,
    9'h030, 9'h031, 9'h032, 9'h033, 9'h034, 9'h035, 9'h036, 9'h037,
    9'h038, 9'h039, 9'h1BA, 9'h0BA, 9'h1BC, 9'h0BB, 9'h1BE, 9'h1BF,
    9'h132, 9'h141, 9'h142, 9'h143, 9'h144, 9'h145, 9'h146, 9'h147,
    9'h148, 9'h149, 9'h14A, 9'h14B, 9'h14C, 9'h14D, 9'h14E, 9'h14F,
    9'h150, 9'h151, 9'h152, 9'h153, 9'h154, 9'h155, 9'h156, 9'h157,
    9'h158, 9'h159, 9'h15A, 9'h0DB, 9'h0DC, 9'h0DD, 9'h136, 9'h1BD,
    9'h0C0, 9'h041, 9'h042, 9'h043, 9'h044, 9'h045, 9'h046, 9'h047,
    9'h048, 9'h049, 9'h04A, 9'h04B, 9'h04C, 9'h04D, 9'h04E, 9'h04F,
    9'h050, 9'h051, 9'h052, 9'h053, 9'h054, 9'h055, 9'h056, 9'h057,
    9'h058, 9'h059, 9'h05A, 9'h1DB, 9'h1DC, 9'h1DD, 9'h1C0
  };

  key_word_t   expected_keys_q[$];
  key_word_t   run_keys_q[$];
  logic        kbd_attached;
  int unsigned mismatches;

  function automatic void stage_key(input logic [7:0] code, input logic rel);
    key_word_t ev;
    ev.key_code    = code;
    ev.is_release  = rel;
    ev.last_of_run = 1'b0;
    run_keys_q.push_back(ev);
  endfunction

  function automatic void stage_tap(input logic [7:0] code);
    stage_key(code, Press);
    stage_key(code, Release);
  endfunction

  function automatic void predict_keystrokes(input logic [CpW-1:0] cp);
    logic [8:0]  entry;
    logic [23:0] cp_wide;
    logic [3:0]  nib;
    int          ndig;
    if (!kbd_attached) begin
      return;
    end
    run_keys_q.delete();
    cp_wide = {3'b000, cp};
    if (cp >= 21'h20 && cp <= 21'h7E) begin
      entry = UsKeymap[cp - 21'h20];
      if (entry[8]) begin
        stage_key(KeyLShift, Press);
      end
      stage_tap(entry[7:0]);
      if (entry[8]) begin
        stage_key(KeyLShift, Release);
      end
    end else begin
      ndig = 1;
      while (ndig < 6 && (cp_wide >> (4 * ndig)) != 0) begin
        ndig++;
      end
      stage_key(KeyLCtrl, Press);
      stage_key(KeyLShift, Press);
      stage_tap(KeyU);
      for (int i = ndig - 1; i >= 0; i--) begin
        nib = cp_wide[4*i +: 4];
        stage_tap(nib < 4'd10 ? KeyDigit0 + 8'(nib) : KeyLetterA + 8'(nib - 4'd10));
      end
      stage_key(KeyLShift, Release);
      stage_key(KeyLCtrl, Release);
    end
    run_keys_q[run_keys_q.size() - 1].last_of_run = 1'b1;
    foreach (run_keys_q[i]) begin
      expected_keys_q.push_back(run_keys_q[i]);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    key_word_t want;
    if (!rst_ni) begin
      expected_keys_q.delete();
      kbd_attached = 1'b1;
      mismatches   = 0;
    end else begin
      if (key_valid_i && key_ready_i) begin
        if (expected_keys_q.size() == 0) begin
          if (mismatches < MaxReported) begin
            $display("%0t: key word %02h rel %0b last %0b with none outstanding",
                     $realtime, key_data_i.key_code, key_data_i.is_release,
                     key_data_i.last_of_run);
          end
          mismatches++;
        end else begin
          want = expected_keys_q.pop_front();
          if (key_data_i.key_code !== want.key_code ||
              key_data_i.is_release !== want.is_release ||
              key_data_i.last_of_run !== want.last_of_run) begin
            if (mismatches < MaxReported) begin
              $display("%0t: key word mismatch: want key %02h rel %0b last %0b, got key %02h rel %0b last %0b",
                       $realtime, want.key_code, want.is_release, want.last_of_run,
                       key_data_i.key_code, key_data_i.is_release, key_data_i.last_of_run);
            end
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        kbd_attached = cfg_data_i.keyboard_attached;
      end
      if (cp_valid_i && cp_ready_i) begin
        predict_keystrokes(cp_data_i.codepoint);
      end
    end
    mismatch_cnt_o <= mismatches;
    outstanding_o  <= expected_keys_q.size();
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - codepoint to keystroke sequencer
// Feeds directed and random codepoints under both keyboard settings, with
// random idling on both channels and one long stall of the key event sink,
// and lets the run checker compare every key event word.
// ----------------------------------------------------------------------------
module testbench;
  import cks_pkg::*;

  localparam int unsigned SettleCycles  = 24;     // covers the longest run
  localparam int unsigned HoldOffCycles = 150;    // long sink stall
  localparam int unsigned TimeoutNs     = 5000000;

  localparam logic KbdOff = 1'b0;
  localparam logic KbdOn  = 1'b1;

  // Edges of the table, both Shift cases, hex lengths one, two, four, five and
  // six, and values past the Unicode range
  localparam logic [CpW-1:0] DirectedCps [24] = '{
    21'h000020, 21'h00007E, 21'h000041, 21'h000061, 21'h000030, 21'h00003A,
    21'h00003B, 21'h000040, 21'h00005F, 21'h000060, 21'h000000, 21'h00001F,
    21'h00000A, 21'h00007F, 21'h00000F, 21'h000010, 21'h000080, 21'h00D800,
    21'h00DFFF, 21'h0FFFFF, 21'h100000, 21'h10FFFF, 21'h1ABCDE, 21'h1FFFFF
  };

  logic        clk_i;
  logic        rst_ni;
  logic        idling;        // random gaps on both sides when set
  logic        hold_off_req;  // asks the sink process for one long stall
  int unsigned mismatch_cnt;
  int unsigned outstanding;

  cks_word_if #(.T(cfg_word_t)) cfg_if ();
  cks_word_if #(.T(cp_word_t))  cp_if ();
  cks_word_if #(.T(key_word_t)) key_if ();

  codepoint_to_keystroke_sequencer_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if.sink),
    .in_i   (cp_if.sink),
    .out_o  (key_if.source)
  );

  keystroke_run_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_if.valid),
    .cfg_ready_i    (cfg_if.ready),
    .cfg_data_i     (cfg_if.data),
    .cp_valid_i     (cp_if.valid),
    .cp_ready_i     (cp_if.ready),
    .cp_data_i      (cp_if.data),
    .key_valid_i    (key_if.valid),
    .key_ready_i    (key_if.ready),
    .key_data_i     (key_if.data),
    .mismatch_cnt_o (mismatch_cnt),
    .outstanding_o  (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit, far beyond the slowest legal run
  initial begin
    #(TimeoutNs);
    $display("FAILED: results differ");
    $finish;
  end

  // Key event sink: stretches of ready, short random holds, and the one long
  // stall on request. Every change lands just after a rising edge.
  initial begin
    key_if.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        key_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (idling && $urandom_range(0, 3) == 0) begin
        key_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        key_if.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  // Offer one codepoint word and wait for it to be taken. Valid stays high
  // on return unless the next call opens a gap.
  task automatic send_codepoint(input logic [CpW-1:0] cp);
    if (idling && $urandom_range(0, 4) == 0) begin
      cp_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    cp_if.valid          <= 1'b1;
    cp_if.data.codepoint <= cp;
    @(posedge clk_i);
    while (!cp_if.ready) @(posedge clk_i);
  endtask

  // Random codepoints: mostly printable text, a share of control codes, and
  // hex values of every length, the full 21-bit field among them
  task automatic send_random(input int unsigned count, input int unsigned stall_at);
    int unsigned     roll;
    int unsigned     ndig;
    logic [CpW-1:0]  cp;
    for (int unsigned n = 0; n < count; n++) begin
      if (n == stall_at) begin
        hold_off_req = 1'b1;
      end
      roll = $urandom_range(0, 9);
      if (roll < 5) begin
        cp = CpW'($urandom_range(32'h20, 32'h7E));
      end else if (roll == 5) begin
        cp = CpW'($urandom_range(0, 32));
        if (cp == 21'd32) begin
          cp = 21'h7F;   // DEL goes by hex entry
        end
      end else if (roll < 9) begin
        ndig = $urandom_range(1, 6);
        cp   = CpW'($urandom & ((32'd1 << (4 * ndig)) - 1));
      end else begin
        cp = CpW'($urandom);
      end
      send_codepoint(cp);
    end
  endtask

  // Stop offering, let every outstanding key event arrive, then allow for a
  // dropped codepoint still in flight. The first edge lets the checker count
  // the run of the word taken just before.
  task automatic drain;
    cp_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Only called with the block idle
  task automatic write_keyboard(input logic attached);
    cfg_if.valid                  <= 1'b1;
    cfg_if.data.keyboard_attached <= attached;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    rst_ni       = 1'b0;
    idling       = 1'b1;
    hold_off_req = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    cp_if.valid  = 1'b0;
    cp_if.data   = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pass with the keyboard attached
    write_keyboard(KbdOn);
    foreach (DirectedCps[i]) begin
      send_codepoint(DirectedCps[i]);
    end
    drain();

    // Bulk random with the long sink stall early on, so the input backs up
    send_random(220, 40);
    drain();

    // Keyboard detached: everything is taken and dropped
    write_keyboard(KbdOff);
    send_codepoint(21'h00007E);
    send_codepoint(21'h1FFFFF);
    send_random(28, 32'hFFFF_FFFF);
    drain();

    write_keyboard(KbdOn);
    send_random(40, 32'hFFFF_FFFF);
    drain();

    // Closing stretch without any idling
    idling = 1'b0;
    send_random(70, 32'hFFFF_FFFF);
    drain();

    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/cks_pkg.sv
rtl/core/cks_word_if.sv
rtl/core/cks_digit_unit.sv
rtl/core/cks_event_seq.sv
rtl/core/codepoint_to_keystroke_sequencer_core.sv
verif/keystroke_run_checker.sv
verif/testbench.sv
